/* rtl/core/swarq_pkg.sv */
package swarq_pkg;

  // command codes of an input item
  localparam logic [1:0] CmdSend = 2'd0;
  localparam logic [1:0] CmdAck  = 2'd1;
  localparam logic [1:0] CmdNack = 2'd2;
  localparam logic [1:0] CmdTick = 2'd3;

  // configuration register indexes
  localparam int unsigned  CfgIdxW         = 2;
  localparam logic [CfgIdxW-1:0] CfgMaxAttempts  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout   = 2'd1;

  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned SeqW       = 8;
  localparam int unsigned AttemptW   = 8;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned TimerBitsDefault = 16;

  localparam logic [AttemptW-1:0] MaxAttemptsReset = 8'd3;
  localparam logic [TimeoutW-1:0] AckTimeoutReset  = 16'd500;

  // exchange state apart from the timer
  typedef struct packed {
    logic                waiting;
    logic [SeqW-1:0]     awaited_seq;
    logic [AttemptW-1:0] attempts;
  } xchg_state_t;

  // one result item
  typedef struct packed {
    logic            transmit;
    logic [SeqW-1:0] transmit_sequence;
    logic            done_res;
    logic            outcome;
    logic            rejected;
    logic            busy_res;
  } result_t;

endpackage

/* rtl/core/swarq_step.sv */
module swarq_step #(
  parameter int unsigned TIMER_BITS = swarq_pkg::TimerBitsDefault
) (
  input  logic [1:0]                          command_i,
  input  logic [swarq_pkg::SeqW-1:0]          sequence_req_i,
  input  logic [swarq_pkg::AttemptW-1:0]      max_attempts_i,
  input  logic [swarq_pkg::TimeoutW-1:0]      ack_timeout_i,
  input  swarq_pkg::xchg_state_t              state_i,
  input  logic [TIMER_BITS-1:0]               elapsed_i,
  output swarq_pkg::xchg_state_t              state_o,
  output logic [TIMER_BITS-1:0]               elapsed_o,
  output swarq_pkg::result_t                  result_o
);

  localparam int unsigned CmpW = (TIMER_BITS > swarq_pkg::TimeoutW) ?
                                 TIMER_BITS : swarq_pkg::TimeoutW;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  logic [swarq_pkg::AttemptW-1:0] limit;
  logic                           retry_ok;
  logic                           seq_match;
  logic [TIMER_BITS-1:0]          elapsed_inc;
  logic                           timed_out;

  // zero attempts behaves as one
  assign limit     = (max_attempts_i == '0) ? swarq_pkg::AttemptW'(1) : max_attempts_i;
  assign retry_ok  = state_i.attempts < limit;
  assign seq_match = state_i.waiting && (sequence_req_i == state_i.awaited_seq);

  // saturating timer; hitting the ceiling counts as a timeout as well
  assign elapsed_inc = (elapsed_i != TimerMax) ? elapsed_i + TIMER_BITS'(1) : elapsed_i;
  assign timed_out   = (CmpW'(elapsed_inc) >= CmpW'(ack_timeout_i)) ||
                       (elapsed_inc == TimerMax);

  always_comb begin
    state_o   = state_i;
    elapsed_o = elapsed_i;
    result_o  = '0;
    case (command_i)
      swarq_pkg::CmdSend: begin
        if (state_i.waiting) begin
          result_o.rejected = 1'b1;
        end else begin
          state_o.waiting     = 1'b1;
          state_o.awaited_seq = sequence_req_i;
          state_o.attempts    = swarq_pkg::AttemptW'(1);
          elapsed_o           = '0;
          result_o.transmit   = 1'b1;
        end
      end
      swarq_pkg::CmdAck: begin
        if (seq_match) begin
          state_o.waiting   = 1'b0;
          result_o.done_res = 1'b1;
        end
      end
      swarq_pkg::CmdNack: begin
        if (seq_match) begin
          if (retry_ok) begin
            state_o.attempts  = state_i.attempts + swarq_pkg::AttemptW'(1);
            elapsed_o         = '0;
            result_o.transmit = 1'b1;
          end else begin
            state_o.waiting   = 1'b0;
            result_o.done_res = 1'b1;
            result_o.outcome  = 1'b1;
          end
        end
      end
      swarq_pkg::CmdTick: begin
        if (state_i.waiting) begin
          elapsed_o = elapsed_inc;
          if (timed_out) begin
            if (retry_ok) begin
              state_o.attempts  = state_i.attempts + swarq_pkg::AttemptW'(1);
              elapsed_o         = '0;
              result_o.transmit = 1'b1;
            end else begin
              state_o.waiting   = 1'b0;
              result_o.done_res = 1'b1;
              result_o.outcome  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.transmit_sequence = state_o.awaited_seq;
    result_o.busy_res          = state_o.waiting;
  end

endmodule

/* rtl/core/swarq_out_buf.sv */
module swarq_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  swarq_pkg::result_t data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output swarq_pkg::result_t out_data_o
);

  logic               out_valid_q;
  logic               skid_valid_q;
  swarq_pkg::result_t out_q;
  swarq_pkg::result_t skid_q;
  logic               pop;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a parked item always sits behind a shown one
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

endmodule

/* rtl/core/stop_and_wait_retransmit_controller_core.sv */
// Stop-and-wait ARQ sender controller.
// Input channel (in_valid_i / in_stall_o): one item per event, command_i is a
// send request, an ack, a nack or a time tick, sequence_req_i the sequence.
// Output channel (out_valid_o / out_stall_i): exactly one result item per
// accepted item, in order: transmit request, awaited sequence, done/outcome,
// rejected and busy flags.
// Config port: cfg_we_i writes cfg_data_i to max_attempts (index 0, low
// byte) or ack_timeout (index 1); other indexes are dropped. Write only
// while no result is pending.
// A result is registered into the output buffer as its item is taken.
// Throughput: one item per cycle while in_stall_o is low; the exchange state
// is updated at the accepting edge, so the next item sees it straight away.
// Stall: results go into a two-entry output buffer (output register plus
// skid entry). An item is still taken while one result waits; in_stall_o
// rises only once both entries hold results.
// Reset: idle, sequence and attempt count zero, timer zero, max_attempts 3,
// ack_timeout 500, output buffer empty.
module stop_and_wait_retransmit_controller_core #(
  parameter int unsigned TIMER_BITS = swarq_pkg::TimerBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [swarq_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [swarq_pkg::CfgDataW-1:0]    cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [swarq_pkg::SeqW-1:0]        sequence_req_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              transmit_o,
  output logic [swarq_pkg::SeqW-1:0]        transmit_sequence_o,
  output logic                              done_res_o,
  output logic                              outcome_o,
  output logic                              rejected_o,
  output logic                              busy_res_o
);

  // config registers
  logic [swarq_pkg::AttemptW-1:0] max_attempts_q;
  logic [swarq_pkg::TimeoutW-1:0] ack_timeout_q;

  // exchange state
  swarq_pkg::xchg_state_t state_q, state_d;
  logic [TIMER_BITS-1:0]  elapsed_q, elapsed_d;

  swarq_pkg::result_t     result_d;
  swarq_pkg::result_t     out_data;
  logic                   buf_full;
  logic                   accept;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_attempts_q <= swarq_pkg::MaxAttemptsReset;
      ack_timeout_q  <= swarq_pkg::AckTimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        swarq_pkg::CfgMaxAttempts: max_attempts_q <= cfg_data_i[swarq_pkg::AttemptW-1:0];
        swarq_pkg::CfgAckTimeout:  ack_timeout_q  <= cfg_data_i[swarq_pkg::TimeoutW-1:0];
        default: begin
          max_attempts_q <= max_attempts_q;
        end
      endcase
    end
  end

  // next state and result for the offered item
  swarq_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .command_i      (command_i),
    .sequence_req_i (sequence_req_i),
    .max_attempts_i (max_attempts_q),
    .ack_timeout_i  (ack_timeout_q),
    .state_i        (state_q),
    .elapsed_i      (elapsed_q),
    .state_o        (state_d),
    .elapsed_o      (elapsed_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      elapsed_q <= '0;
    end else if (accept) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
    end
  end

  swarq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result_d),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign transmit_o          = out_data.transmit;
  assign transmit_sequence_o = out_data.transmit_sequence;
  assign done_res_o          = out_data.done_res;
  assign outcome_o           = out_data.outcome;
  assign rejected_o          = out_data.rejected;
  assign busy_res_o          = out_data.busy_res;

  // a waiting exchange has made at least one transmission
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q.waiting |-> (state_q.attempts != '0))
    else $error("waiting with no attempt counted");

  // a finished exchange is no longer busy, and a failure is always a finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && done_res_o) |-> !busy_res_o)
    else $error("done result still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && outcome_o) |-> done_res_o)
    else $error("failure outcome without done");

  // a transmit request only leaves while busy, never with a rejection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && transmit_o) |-> (busy_res_o && !rejected_o))
    else $error("transmit without an exchange in progress");

  // an idle accepted item leaves the exchange state alone unless it starts one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (accept && !state_q.waiting && (command_i != swarq_pkg::CmdSend))
                   |=> $stable(state_q))
    else $error("idle event changed the exchange state");

endmodule
